/* rtl/rle_pattern_run_parser_assert.svh */
// Assertion macros used by the parser back end (rlp_back).
// Simulation builds get the checks; synthesis builds get empty bodies.
`ifndef RLE_PATTERN_RUN_PARSER_ASSERT_SVH
`define RLE_PATTERN_RUN_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
// check only outside reset
`define RLP_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check at every edge, reset included
`define RLP_ASSERT_ON(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RLP_ASSERT_RST(label, clk, rst_n, prop, msg)
`define RLP_ASSERT_ON(label, clk, prop, msg)
`endif
`endif

/* rtl/rlp_pkg.sv */
`default_nettype none
package rlp_pkg;

    localparam int COORD_BITS = 16;
    localparam int FIELD_W    = 16;
    localparam int CFG_W      = 16;
    localparam int BYTE_W     = 8;
    localparam int DIGIT_W    = 4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // ASCII codes the parser reacts to
    localparam logic [BYTE_W-1:0] CH_HASH   = 8'h23;
    localparam logic [BYTE_W-1:0] CH_X      = 8'h78;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_O      = 8'h6F;
    localparam logic [BYTE_W-1:0] CH_B      = 8'h62;
    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_BANG   = 8'h21;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;

    localparam logic KIND_RUN = 1'b0;
    localparam logic KIND_END = 1'b1;

    typedef enum logic [2:0] {
        OP_DIGIT,
        OP_HDR_X,
        OP_HDR_Y,
        OP_RUN,
        OP_SKIP,
        OP_ROW,
        OP_END
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [DIGIT_W-1:0] digit;
    } t_tok;

    typedef struct packed {
        logic [CFG_W-1:0] grid_cols;
        logic [CFG_W-1:0] grid_rows;
    } t_cfg;

endpackage
`default_nettype wire

/* rtl/rle_pattern_run_parser.sv */
`default_nettype none
// Run-length encoded pattern parser. Feed the pattern text one ASCII byte per
// transfer on i_in_byte; live runs come out as (row, column, length) with
// o_out_kind low, and the '!' terminator gives one result with o_out_kind high
// and zero fields, after which all bytes are ignored until reset. Comment lines
// and the rule line are skipped, and the header x and y values center the
// pattern in the grid set by grid_cols (address 0) and grid_rows (address 4);
// write those only while the parser is idle. While o_in_stall is low the
// parser takes one byte every cycle: the front end classifies each byte in the
// cycle it transfers and hands a token through a four-entry queue to the back
// end, which updates the counters and cursors and places a result in a
// one-entry output register. A result is registered in the queue and then in
// the output register before it is offered. While a waiting result is stalled,
// the queue absorbs up to four more tokens before o_in_stall rises; bytes that
// make no token do not occupy the queue.
module rle_pattern_run_parser (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [rlp_pkg::BYTE_W-1:0]  i_in_byte,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic                             o_out_kind,
    output logic [rlp_pkg::FIELD_W-1:0]      o_out_row,
    output logic [rlp_pkg::FIELD_W-1:0]      o_out_col,
    output logic [rlp_pkg::FIELD_W-1:0]      o_out_length,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [2:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import rlp_pkg::*;

    localparam logic             REG_GRID_COLS = 1'b0;
    localparam logic             REG_GRID_ROWS = 1'b1;
    localparam logic [CFG_W-1:0] GRID_RESET    = CFG_W'(256);

    t_cfg r_cfg;
    logic cfg_write;
    logic in_accept;
    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    t_tok front_tok;
    t_tok q_tok;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_cols <= GRID_RESET;
            r_cfg.grid_rows <= GRID_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_GRID_COLS: r_cfg.grid_cols <= pwdata[CFG_W-1:0];
                REG_GRID_ROWS: r_cfg.grid_rows <= pwdata[CFG_W-1:0];
                default:       r_cfg.grid_cols <= r_cfg.grid_cols;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_GRID_COLS: prdata = 32'(r_cfg.grid_cols);
            REG_GRID_ROWS: prdata = 32'(r_cfg.grid_rows);
            default:       prdata = '0;
        endcase
    end

    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    rlp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_in_byte),
        .o_push   (q_push),
        .o_tok    (front_tok)
    );

    rlp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_tok   (front_tok),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_tok   (q_tok)
    );

    rlp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_valid    (q_valid),
        .i_q_tok      (q_tok),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_kind   (o_out_kind),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_out_length (o_out_length)
    );

endmodule
`default_nettype wire

/* rtl/rlp_front.sv */
`default_nettype none
module rlp_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_accept,
    input  wire logic [rlp_pkg::BYTE_W-1:0] i_byte,
    output logic                            o_push,
    output rlp_pkg::t_tok                   o_tok
);
    import rlp_pkg::*;

    localparam logic [2:0] PH_LINE    = 3'd0;
    localparam logic [2:0] PH_COMMENT = 3'd1;
    localparam logic [2:0] PH_HDR_X   = 3'd2;
    localparam logic [2:0] PH_HDR_Y   = 3'd3;
    localparam logic [2:0] PH_RULE    = 3'd4;
    localparam logic [2:0] PH_BODY    = 3'd5;
    localparam logic [2:0] PH_DONE    = 3'd6;

    logic [2:0] r_phase;
    logic [2:0] n_phase;
    logic       is_digit;
    logic       tok_valid;

    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);

    always_comb begin
        n_phase   = r_phase;
        tok_valid = 1'b0;
        o_tok.op    = OP_DIGIT;
        o_tok.digit = i_byte[DIGIT_W-1:0];
        unique case (r_phase)
            PH_LINE: begin
                if (i_byte == CH_HASH) begin
                    n_phase = PH_COMMENT;
                end else if (i_byte == CH_X) begin
                    n_phase = PH_HDR_X;
                end
            end
            PH_COMMENT: begin
                if (i_byte == CH_NL) begin
                    n_phase = PH_LINE;
                end
            end
            PH_HDR_X, PH_HDR_Y: begin
                if (is_digit) begin
                    tok_valid = 1'b1;
                end else if (i_byte == CH_COMMA) begin
                    tok_valid = 1'b1;
                    o_tok.op  = (r_phase == PH_HDR_X) ? OP_HDR_X : OP_HDR_Y;
                    n_phase   = (r_phase == PH_HDR_X) ? PH_HDR_Y : PH_RULE;
                end
            end
            PH_RULE: begin
                if (i_byte == CH_NL) begin
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                tok_valid = 1'b1;
                if (is_digit) begin
                    o_tok.op = OP_DIGIT;
                end else if (i_byte == CH_O) begin
                    o_tok.op = OP_RUN;
                end else if (i_byte == CH_B) begin
                    o_tok.op = OP_SKIP;
                end else if (i_byte == CH_DOLLAR) begin
                    o_tok.op = OP_ROW;
                end else if (i_byte == CH_BANG) begin
                    o_tok.op = OP_END;
                    n_phase  = PH_DONE;
                end else begin
                    tok_valid = 1'b0;
                end
            end
            default: begin
                // ended, or the unused code: ignore everything
                n_phase = r_phase;
            end
        endcase
    end

    assign o_push = i_accept && tok_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LINE;
        end else if (i_accept) begin
            r_phase <= n_phase;
        end
    end

endmodule
`default_nettype wire

/* rtl/rlp_queue.sv */
`default_nettype none
module rlp_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire rlp_pkg::t_tok i_tok,
    output logic               o_full,
    output logic               o_valid,
    input  wire logic          i_pop,
    output rlp_pkg::t_tok      o_tok
);
    import rlp_pkg::*;

    t_tok              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_tok   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/rlp_back.sv */
`default_nettype none
`include "rle_pattern_run_parser_assert.svh"
module rlp_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire rlp_pkg::t_cfg               i_cfg,
    input  wire logic                        i_q_valid,
    input  wire rlp_pkg::t_tok               i_q_tok,
    output logic                             o_pop,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic                             o_out_kind,
    output logic [rlp_pkg::FIELD_W-1:0]      o_out_row,
    output logic [rlp_pkg::FIELD_W-1:0]      o_out_col,
    output logic [rlp_pkg::FIELD_W-1:0]      o_out_length
);
    import rlp_pkg::*;

    localparam int ACC_W = COORD_BITS + 4;
    localparam int CEN_W = (COORD_BITS > CFG_W) ? COORD_BITS : CFG_W;
    localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

    logic [COORD_BITS-1:0] r_acc, n_acc;
    logic                  r_digits, n_digits;
    logic [COORD_BITS-1:0] r_start_col, n_start_col;
    logic [COORD_BITS-1:0] r_row, n_row;
    logic [COORD_BITS-1:0] r_col, n_col;

    logic                  r_out_valid;
    logic                  r_out_kind;
    logic [FIELD_W-1:0]    r_out_row;
    logic [FIELD_W-1:0]    r_out_col;
    logic [FIELD_W-1:0]    r_out_len;

    logic                  slot_free;
    logic                  emit;
    logic                  emit_kind;
    logic [ACC_W-1:0]      acc_wide;
    logic [COORD_BITS-1:0] acc_sat;
    logic [COORD_BITS-1:0] run_len;
    logic [COORD_BITS:0]   col_sum;
    logic [COORD_BITS:0]   row_sum;
    logic [COORD_BITS-1:0] col_sat;
    logic [COORD_BITS-1:0] row_sat;

    // half grid minus half size, floored at zero
    function automatic logic [COORD_BITS-1:0] centre(
        input logic [CFG_W-1:0]      grid,
        input logic [COORD_BITS-1:0] size
    );
        logic [CEN_W-1:0] g;
        logic [CEN_W-1:0] s;
        g = CEN_W'(grid) >> 1;
        s = CEN_W'(size) >> 1;
        return (s > g) ? '0 : COORD_BITS'(g - s);
    endfunction

    assign slot_free = !r_out_valid || !i_out_stall;
    assign o_pop     = i_q_valid && slot_free;

    assign acc_wide = (ACC_W'(r_acc) << 3) + (ACC_W'(r_acc) << 1) + ACC_W'(i_q_tok.digit);
    assign acc_sat  = (acc_wide > ACC_W'(COORD_MAX)) ? COORD_MAX : acc_wide[COORD_BITS-1:0];
    assign run_len  = r_digits ? r_acc : COORD_BITS'(1);
    assign col_sum  = {1'b0, r_col} + {1'b0, run_len};
    assign row_sum  = {1'b0, r_row} + {1'b0, run_len};
    assign col_sat  = col_sum[COORD_BITS] ? COORD_MAX : col_sum[COORD_BITS-1:0];
    assign row_sat  = row_sum[COORD_BITS] ? COORD_MAX : row_sum[COORD_BITS-1:0];

    always_comb begin
        n_acc       = r_acc;
        n_digits    = r_digits;
        n_start_col = r_start_col;
        n_row       = r_row;
        n_col       = r_col;
        emit        = 1'b0;
        emit_kind   = KIND_RUN;
        if (o_pop) begin
            unique case (i_q_tok.op)
                OP_DIGIT: begin
                    n_acc    = acc_sat;
                    n_digits = 1'b1;
                end
                OP_HDR_X: begin
                    n_start_col = centre(i_cfg.grid_cols, r_acc);
                    n_col       = n_start_col;
                    n_acc       = '0;
                    n_digits    = 1'b0;
                end
                OP_HDR_Y: begin
                    n_row    = centre(i_cfg.grid_rows, r_acc);
                    n_acc    = '0;
                    n_digits = 1'b0;
                end
                OP_RUN: begin
                    emit     = (run_len != '0);
                    n_col    = col_sat;
                    n_acc    = '0;
                    n_digits = 1'b0;
                end
                OP_SKIP: begin
                    n_col    = col_sat;
                    n_acc    = '0;
                    n_digits = 1'b0;
                end
                OP_ROW: begin
                    n_row    = row_sat;
                    n_col    = r_start_col;
                    n_acc    = '0;
                    n_digits = 1'b0;
                end
                OP_END: begin
                    emit      = 1'b1;
                    emit_kind = KIND_END;
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_digits    <= 1'b0;
            r_start_col <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_digits    <= n_digits;
            r_start_col <= n_start_col;
            r_row       <= n_row;
            r_col       <= n_col;
            if (slot_free) begin
                r_out_valid <= emit;
            end
        end
    end

    // payload: load only when the slot is free, hold while stalled
    always_ff @(posedge i_clk) begin
        if (slot_free) begin
            r_out_kind <= emit_kind;
            if (emit_kind == KIND_END) begin
                r_out_row <= '0;
                r_out_col <= '0;
                r_out_len <= '0;
            end else begin
                r_out_row <= FIELD_W'(r_row);
                r_out_col <= FIELD_W'(r_col);
                r_out_len <= FIELD_W'(run_len);
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_kind   = r_out_kind;
    assign o_out_row    = r_out_row;
    assign o_out_col    = r_out_col;
    assign o_out_length = r_out_len;

    `RLP_ASSERT_RST(a_end_zero, i_clk, i_rst_n,
        (r_out_valid && r_out_kind == KIND_END) |->
            (r_out_row == '0 && r_out_col == '0 && r_out_len == '0),
        "end marker carries nonzero fields")
    `RLP_ASSERT_RST(a_run_nonzero, i_clk, i_rst_n,
        (r_out_valid && r_out_kind == KIND_RUN) |-> (r_out_len != '0),
        "live run of zero length")
    `RLP_ASSERT_RST(a_row_home, i_clk, i_rst_n,
        (o_pop && i_q_tok.op == OP_ROW) |=> (r_col == r_start_col && !r_digits),
        "row advance did not return column")
    `RLP_ASSERT_RST(a_digit_seen, i_clk, i_rst_n,
        (o_pop && i_q_tok.op == OP_DIGIT) |=> r_digits,
        "digit not recorded")
    `RLP_ASSERT_ON(a_reset_empty, i_clk, !i_rst_n |=> !r_out_valid, "result pending after reset")

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import rlp_pkg::*;

    localparam int          RANDOM_BYTES  = 755;
    localparam int          SETTLE_CYCLES = 12;
    localparam int          TAIL_CYCLES   = 30;
    localparam longint      TIMEOUT_NS    = 5_000_000;
    localparam logic [2:0]  ADDR_GRID_COLS = 3'd0;
    localparam logic [2:0]  ADDR_GRID_ROWS = 3'd4;
    localparam logic [15:0] COORD_TOP      = 16'hFFFF;

    typedef enum logic [2:0] {
        AT_LINE,
        IN_COMMENT,
        IN_HDR_X,
        IN_HDR_Y,
        IN_RULE,
        IN_BODY,
        ENDED
    } t_phase;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    typedef struct packed {
        logic               kind;
        logic [FIELD_W-1:0] row;
        logic [FIELD_W-1:0] col;
        logic [FIELD_W-1:0] length;
    } t_run;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_in_valid   = 1'b0;
    logic [BYTE_W-1:0] i_in_byte    = '0;
    logic              i_out_stall  = 1'b0;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [2:0]        paddr        = '0;
    logic [31:0]       pwdata       = '0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic              o_out_kind;
    logic [FIELD_W-1:0] o_out_row;
    logic [FIELD_W-1:0] o_out_col;
    logic [FIELD_W-1:0] o_out_length;
    logic [31:0]       prdata;
    logic              pready;

    rle_pattern_run_parser u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_byte   (i_in_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_kind  (o_out_kind),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_out_length(o_out_length),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #6 i_clk = ~i_clk;

    // decoder state as seen from outside
    logic [CFG_W-1:0]      grid_cols_set = 16'd256;
    logic [CFG_W-1:0]      grid_rows_set = 16'd256;
    t_phase                phase_now     = AT_LINE;
    logic [COORD_BITS-1:0] count_acc     = '0;
    logic                  count_given   = 1'b0;
    logic [COORD_BITS-1:0] origin_col    = '0;
    logic [COORD_BITS-1:0] row_at        = '0;
    logic [COORD_BITS-1:0] col_at        = '0;

    t_run runs_due[$];
    int   mismatches  = 0;
    int   bytes_sent  = 0;
    int   burst_left  = 0;

    function automatic logic [15:0] sat_sum(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? COORD_TOP : s[15:0];
    endfunction

    function automatic logic [15:0] centered_start(input logic [15:0] grid,
                                                   input logic [15:0] size);
        logic [15:0] g;
        logic [15:0] s;
        g = grid >> 1;
        s = size >> 1;
        return (s > g) ? 16'd0 : g - s;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_noise();
        logic [BYTE_W-1:0] v;
        // keep the terminator out of random text
        do v = BYTE_W'($urandom_range(0, 255)); while (v == CH_BANG);
        return v;
    endfunction

    task automatic take_digit(input logic [BYTE_W-1:0] c);
        logic [31:0] v;
        v = count_acc * 32'd10 + 32'(c - CH_ZERO);
        count_acc   = (v > 32'(COORD_TOP)) ? COORD_TOP : v[15:0];
        count_given = 1'b1;
    endtask

    task automatic decode_byte(input logic [BYTE_W-1:0] c);
        logic        is_digit;
        logic [15:0] len;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        case (phase_now)
            AT_LINE: begin
                if (c == CH_HASH)
                    phase_now = IN_COMMENT;
                else if (c == CH_X)
                    phase_now = IN_HDR_X;
            end
            IN_COMMENT: begin
                if (c == CH_NL)
                    phase_now = AT_LINE;
            end
            IN_HDR_X, IN_HDR_Y: begin
                if (is_digit) begin
                    take_digit(c);
                end else if (c == CH_COMMA) begin
                    if (phase_now == IN_HDR_X) begin
                        origin_col = centered_start(grid_cols_set, count_acc);
                        col_at     = origin_col;
                        phase_now  = IN_HDR_Y;
                    end else begin
                        row_at    = centered_start(grid_rows_set, count_acc);
                        phase_now = IN_RULE;
                    end
                    count_acc   = '0;
                    count_given = 1'b0;
                end
            end
            IN_RULE: begin
                if (c == CH_NL)
                    phase_now = IN_BODY;
            end
            IN_BODY: begin
                if (is_digit) begin
                    take_digit(c);
                end else if (c == CH_O || c == CH_B || c == CH_DOLLAR) begin
                    len         = count_given ? count_acc : 16'd1;
                    count_acc   = '0;
                    count_given = 1'b0;
                    if (c == CH_O) begin
                        if (len != 0)
                            runs_due.push_back('{KIND_RUN, row_at, col_at, len});
                        col_at = sat_sum(col_at, len);
                    end else if (c == CH_B) begin
                        col_at = sat_sum(col_at, len);
                    end else begin
                        row_at = sat_sum(row_at, len);
                        col_at = origin_col;
                    end
                end else if (c == CH_BANG) begin
                    phase_now = ENDED;
                    runs_due.push_back('{KIND_END, 16'd0, 16'd0, 16'd0});
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 30);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        decode_byte(b);
        bytes_sent++;
        burst_left--;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // hold input until every run is out and the pipeline is empty
    task automatic settle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (runs_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_cycle(input logic wr, input logic [2:0] addr,
                             input logic [31:0] data, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [CFG_W-1:0] value);
        logic [31:0] unused;
        // upper bits carry junk; only the low half is kept
        apb_cycle(1'b1, addr, {16'($urandom), value}, unused);
        case (addr)
            ADDR_GRID_COLS: grid_cols_set = value;
            ADDR_GRID_ROWS: grid_rows_set = value;
            default: ;
        endcase
    endtask

    task automatic check_reg(input logic [2:0] addr);
        logic [31:0] got;
        logic [31:0] want;
        apb_cycle(1'b0, addr, 32'd0, got);
        want = (addr == ADDR_GRID_COLS) ? {16'd0, grid_cols_set} : {16'd0, grid_rows_set};
        if (got !== want) begin
            $display("%0t: register %0d read expected %h actual %h", $time, addr, want, got);
            mismatches++;
        end
    endtask

    task automatic test_registers();
        check_reg(ADDR_GRID_COLS);
        check_reg(ADDR_GRID_ROWS);
        write_reg(ADDR_GRID_COLS, 16'd1);
        write_reg(ADDR_GRID_ROWS, COORD_TOP);
        check_reg(ADDR_GRID_COLS);
        check_reg(ADDR_GRID_ROWS);
        write_reg(ADDR_GRID_COLS, 16'd0);
        write_reg(ADDR_GRID_ROWS, 16'd1);
        check_reg(ADDR_GRID_COLS);
        check_reg(ADDR_GRID_ROWS);
    endtask

    task automatic test_comment_lines();
        send_text("#C o3b!$\n");
        send_text("\n #\n");
    endtask

    // missing x value centers the columns; rows use a zero grid and a saturated y
    task automatic test_header();
        settle();
        write_reg(ADDR_GRID_COLS, COORD_TOP);
        check_reg(ADDR_GRID_COLS);
        send_text("x = ,");
        settle();
        write_reg(ADDR_GRID_ROWS, 16'd0);
        check_reg(ADDR_GRID_ROWS);
        send_text(" y = 123456, rule = B3/S23\n");
    endtask

    task automatic test_directed_body();
        send_text("3ob2b0o0b0$o1z2o");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("$2$99999oo4b$o");
    endtask

    task automatic test_random_body();
        int  useful;
        int  pick;
        int  n;
        bit  paused;
        logic [BYTE_W-1:0] op;
        useful = 0;
        paused = 0;
        while (useful < RANDOM_BYTES) begin
            if (!paused && useful > RANDOM_BYTES / 2) begin
                settle();
                paused = 1;
            end
            n = bytes_sent;
            if ($urandom_range(0, 99) < 80) begin
                pick = $urandom_range(0, 99);
                op   = (pick < 45) ? CH_O : (pick < 80) ? CH_B : CH_DOLLAR;
                pick = $urandom_range(0, 19);
                if (op == CH_DOLLAR) begin
                    // keep rows well below saturation
                    if (pick < 12)
                        send_text($sformatf("%0d", $urandom_range(0, 3)));
                end else if (pick >= 6 && pick < 16) begin
                    send_text($sformatf("%0d", $urandom_range(1, 99)));
                end else if (pick == 16 || pick == 17) begin
                    send_text($sformatf("%0d", $urandom_range(100, 99999)));
                end else if (pick == 18) begin
                    send_text("0");
                end else if (pick == 19) begin
                    send_text($sformatf("0%0d", $urandom_range(0, 9)));
                end
                if ($urandom_range(0, 9) == 0)
                    send_byte(pick_noise());
                send_byte(op);
            end else begin
                send_byte(pick_noise());
            end
            useful += bytes_sent - n;
        end
    endtask

    task automatic test_pattern_end();
        send_text("70000$2o!");
        // ignored after the end
        send_text("3o$!x#\n");
        i_in_valid <= 1'b0;
    endtask

    t_stall_mode stall_mode = STALL_NONE;
    int          mode_left  = 0;
    int          cycle_cnt  = 0;

    always @(posedge i_clk) begin : out_side
        t_run got;
        t_run want;
        cycle_cnt++;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got = '{o_out_kind, o_out_row, o_out_col, o_out_length};
                if (runs_due.size() == 0) begin
                    $display("%0t: unexpected result kind %0d row %0d col %0d length %0d",
                             $time, got.kind, got.row, got.col, got.length);
                    mismatches++;
                end else begin
                    want = runs_due.pop_front();
                    if (got !== want) begin
                        $display("%0t: expected kind %0d row %0d col %0d length %0d", $time,
                                 want.kind, want.row, want.col, want.length);
                        $display("%0t:   actual kind %0d row %0d col %0d length %0d", $time,
                                 got.kind, got.row, got.col, got.length);
                        mismatches++;
                    end
                end
            end
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 150);
            end
            mode_left--;
            case (stall_mode)
                STALL_NONE:     i_out_stall <= 1'b0;
                STALL_LIGHT:    i_out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:    i_out_stall <= ($urandom_range(0, 3) != 0);
                STALL_PERIODIC: i_out_stall <= ((cycle_cnt % 5) < 2);
                default:        i_out_stall <= 1'b0;
            endcase
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_registers();
        test_comment_lines();
        test_header();
        test_directed_body();
        test_random_body();
        test_pattern_end();
        while (runs_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (runs_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, runs_due.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
